// ===== rtl/drld_pkg.sv =====
`default_nettype none

package drld_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CAUSE_W = 2;

    // end cause codes, reported with the last result of a list
    localparam logic [CAUSE_W-1:0] CAUSE_EXHAUSTED = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_ZERO_HDR  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_TRUNCATED = 2'd2;

    typedef struct packed {
        logic signed [WORD_W-1:0] run_start_cluster;
        logic [WORD_W-1:0]        run_length_clusters;
        logic                     run_valid;
        logic                     list_end;
        logic [CAUSE_W-1:0]       end_cause;
    } t_run_result;

endpackage

`default_nettype wire

// ===== rtl/drld_parse.sv =====
`default_nettype none

module drld_parse (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last_byte,
    output logic                       o_has_result,
    output drld_pkg::t_run_result      o_result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    logic [1:0]  r_phase,      n_phase;
    logic [3:0]  r_len_left,   n_len_left;
    logic [3:0]  r_off_left,   n_off_left;
    logic [3:0]  r_pos,        n_pos;
    logic [3:0]  r_off_cnt,    n_off_cnt;
    logic [63:0] r_len_acc,    n_len_acc;
    logic [63:0] r_off_acc,    n_off_acc;
    logic [63:0] r_cluster,    n_cluster;
    logic [1:0]  r_stop_cause, n_stop_cause;

    logic [63:0] w_ins;
    logic [63:0] w_fin_len;
    logic [63:0] w_fin_off;
    logic [63:0] w_ext;
    logic [63:0] w_cluster_sum;
    logic        w_finish;
    logic        w_run_valid;
    logic [1:0]  w_cause;

    // bytes past the eighth of a field are dropped
    assign w_ins = r_pos[3] ? 64'd0 : ({56'd0, i_data_byte} << {r_pos[2:0], 3'b000});

    assign w_fin_len = (r_phase == PH_LENGTH) ? (r_len_acc | w_ins) : r_len_acc;
    assign w_fin_off = (r_phase == PH_OFFSET) ? (r_off_acc | w_ins) : r_off_acc;

    // sign extension only for offsets of one to seven bytes
    always_comb begin
        w_ext = 64'd0;
        for (int k = 1; k < 8; k++) begin
            if (r_off_cnt == 4'(k) && w_fin_off[8*k-1]) begin
                w_ext = {64{1'b1}} << (8*k);
            end
        end
    end

    assign w_cluster_sum = r_cluster + (w_fin_off | w_ext);

    always_comb begin
        n_phase      = r_phase;
        n_len_left   = r_len_left;
        n_off_left   = r_off_left;
        n_pos        = r_pos;
        n_off_cnt    = r_off_cnt;
        n_len_acc    = r_len_acc;
        n_off_acc    = r_off_acc;
        n_cluster    = r_cluster;
        n_stop_cause = r_stop_cause;
        w_finish     = 1'b0;
        w_cause      = drld_pkg::CAUSE_EXHAUSTED;

        unique case (r_phase)
            PH_HEADER: begin
                if (i_data_byte == 8'd0) begin
                    n_phase      = PH_STOP;
                    n_stop_cause = drld_pkg::CAUSE_ZERO_HDR;
                end else begin
                    n_len_left = i_data_byte[3:0];
                    n_off_left = i_data_byte[7:4];
                    n_off_cnt  = i_data_byte[7:4];
                    n_pos      = 4'd0;
                    n_len_acc  = 64'd0;
                    n_off_acc  = 64'd0;
                    n_phase    = (i_data_byte[3:0] != 4'd0) ? PH_LENGTH : PH_OFFSET;
                end
            end
            PH_LENGTH: begin
                n_len_acc  = w_fin_len;
                n_pos      = r_pos + 4'd1;
                n_len_left = r_len_left - 4'd1;
                if (r_len_left == 4'd1) begin
                    n_pos = 4'd0;
                    if (r_off_left == 4'd0) begin
                        w_finish = 1'b1;
                    end else begin
                        n_phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET: begin
                n_off_acc  = w_fin_off;
                n_pos      = r_pos + 4'd1;
                n_off_left = r_off_left - 4'd1;
                if (r_off_left == 4'd1) begin
                    w_finish = 1'b1;
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase

        if (w_finish) begin
            n_cluster = w_cluster_sum;
            n_phase   = PH_HEADER;
            n_pos     = 4'd0;
        end

        if (i_last_byte) begin
            priority if (n_phase == PH_LENGTH || n_phase == PH_OFFSET) begin
                w_cause = drld_pkg::CAUSE_TRUNCATED;
            end else if (n_phase == PH_STOP) begin
                w_cause = n_stop_cause;
            end else begin
                w_cause = drld_pkg::CAUSE_EXHAUSTED;
            end
            // list done, next byte opens a fresh list at cluster zero
            n_phase      = PH_HEADER;
            n_len_left   = 4'd0;
            n_off_left   = 4'd0;
            n_pos        = 4'd0;
            n_off_cnt    = 4'd0;
            n_len_acc    = 64'd0;
            n_off_acc    = 64'd0;
            n_cluster    = 64'd0;
            n_stop_cause = 2'd0;
        end
    end

    assign w_run_valid  = w_finish && (w_fin_len != 64'd0);
    assign o_has_result = w_run_valid || i_last_byte;

    always_comb begin
        o_result.run_start_cluster   = w_run_valid ? w_cluster_sum : 64'd0;
        o_result.run_length_clusters = w_run_valid ? w_fin_len : 64'd0;
        o_result.run_valid           = w_run_valid;
        o_result.list_end            = i_last_byte;
        o_result.end_cause           = i_last_byte ? w_cause : drld_pkg::CAUSE_EXHAUSTED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_len_left   <= 4'd0;
            r_off_left   <= 4'd0;
            r_pos        <= 4'd0;
            r_off_cnt    <= 4'd0;
            r_len_acc    <= 64'd0;
            r_off_acc    <= 64'd0;
            r_cluster    <= 64'd0;
            r_stop_cause <= 2'd0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_len_left   <= n_len_left;
            r_off_left   <= n_off_left;
            r_pos        <= n_pos;
            r_off_cnt    <= n_off_cnt;
            r_len_acc    <= n_len_acc;
            r_off_acc    <= n_off_acc;
            r_cluster    <= n_cluster;
            r_stop_cause <= n_stop_cause;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/data_run_list_decoder.sv =====
// Run list decoder: takes the bytes of a data run list one per request on the
// slave stream, tlast on the final byte, and gives one result for each run
// with a nonzero length plus one for the final byte of the list, merged if
// that byte ends a run (tlast set, tuser[2:1] = end cause: 0 data exhausted,
// 1 zero header, 2 truncated run). A result carries the running start cluster
// and the run length in tdata; for a result with no run both are zero. One
// byte is taken every cycle unless the result side stalls; a byte passes an
// input register and one step of the parser, which updates its state and
// forms the result (byte insert, offset sign extension, 64-bit cluster add)
// combinationally, into the result register. Cluster state is cleared after each final byte.
`default_nettype none

module data_run_list_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic         i_s_axis_tlast,   // last_byte
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [127:0]      o_m_axis_tdata,   // [63:0] run_start_cluster,
                                                // [127:64] run_length_clusters
    output logic [2:0]        o_m_axis_tuser,   // [0] run_valid, [2:1] end_cause
    output logic              o_m_axis_tlast    // list_end
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    drld_pkg::t_run_result r_out;

    logic                  w_out_free;
    logic                  w_step;
    logic                  w_has_result;
    drld_pkg::t_run_result w_result;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    drld_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_step),
        .i_data_byte  (r_in_byte),
        .i_last_byte  (r_in_last),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.run_length_clusters, r_out.run_start_cluster};
    assign o_m_axis_tuser  = {r_out.end_cause, r_out.run_valid};
    assign o_m_axis_tlast  = r_out.list_end;

    // a result with no run carries zero cluster and length
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == 128'd0)
        else $error("result without run has nonzero payload");

    // every result is either a run or the end of a list
    a_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[0] || o_m_axis_tlast)
        else $error("result with neither run nor list end");

    // end cause only on the final result, and never the unused code
    a_cause_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> o_m_axis_tuser[2:1] == 2'd0)
        else $error("end cause outside list end");

    a_cause_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[2:1] != 2'd3)
        else $error("illegal end cause");

    // a held byte waits in the input register while the result side stalls
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("input register lost a byte during stall");

endmodule

`default_nettype wire
